@@ rtl/core/pcf_pkg.sv @@
// Package for the path curve flattener: command codes, controller/datapath
// command and status structs, and the constants of the curve parameter.
// No dependencies.
package pcf_pkg;

   // Path command codes carried on the op field.
   typedef enum logic [3:0] {
      OP_MOVE   = 4'd0,
      OP_LINE   = 4'd1,
      OP_HLINE  = 4'd2,
      OP_VLINE  = 4'd3,
      OP_CUBIC  = 4'd4,
      OP_SCUBIC = 4'd5,
      OP_QUAD   = 4'd6,
      OP_SQUAD  = 4'd7,
      OP_CLOSE  = 4'd8,
      OP_END    = 4'd9
   } op_type;

   // How many results a command gives.
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_SINGLE,
      KIND_CURVE
   } kind_type;

   // Curve parameter t is unsigned Q1.16, held as quotient and remainder
   // of (k*196608 + 50) / 100, which advances by 1966 rem 8 per step.
   localparam int TQ_WIDTH   = 20;
   localparam int TR_WIDTH   = 7;
   localparam int T_WIDTH    = 17;
   localparam int T_Q_STEP   = 1966;
   localparam int T_R_STEP   = 8;
   localparam int T_R_START  = 50;
   localparam int T_DIVISOR  = 100;
   localparam int T_ONE      = 65536;
   localparam int ROUND_HALF = 32768;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic resolve;
      logic mul;
      logic acc;
      logic first_level;
      logic emit_pt;
      logic emit_end;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      kind_type kind;
      logic     cubic;
      logic     out_busy;
   } status_type;

endpackage

@@ rtl/core/pcf_ctrl.sv @@
// Controller state machine of the path curve flattener.
// Depends on pcf_pkg for the command and status structs.
module pcf_ctrl #(
   parameter int CURVE_STEPS = 34
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pcf_pkg::status_type status,
   output pcf_pkg::cmd_type    cmd
);

   localparam int KW = (CURVE_STEPS > 2) ? $clog2(CURVE_STEPS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_MUL,
      S_ACC,
      S_EMIT_PT,
      S_EMIT_END
   } state_type;

   state_type       state_ff, state_in;
   logic [1:0]      level_ff, level_in;
   logic [KW-1:0]   k_ff, k_in;
   logic [1:0]      final_level;

   assign final_level = status.cubic ? 2'd3 : 2'd2;

   // Commands follow from the state and level, gated by req_valid and the output stall.
   assign req_ready        = (state_ff == S_IDLE);
   assign cmd.capture      = (state_ff == S_IDLE) && req_valid;
   assign cmd.resolve      = (state_ff == S_PREP);
   assign cmd.mul          = (state_ff == S_MUL);
   assign cmd.acc          = (state_ff == S_ACC);
   assign cmd.first_level  = (level_ff == 2'd1);
   assign cmd.emit_pt      = (state_ff == S_EMIT_PT) && !status.out_busy;
   assign cmd.emit_end     = (state_ff == S_EMIT_END) && !status.out_busy;

   // Next state, level and step count.
   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      k_in     = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_PREP;
         end
         S_PREP: begin
            level_in = 2'd1;
            k_in     = '0;
            unique case (status.kind)
               pcf_pkg::KIND_SINGLE: state_in = S_EMIT_END;
               pcf_pkg::KIND_CURVE:  state_in = S_MUL;
               default:              state_in = S_IDLE;
            endcase
         end
         S_MUL: state_in = S_ACC;
         S_ACC: begin
            if (level_ff == final_level) begin
               state_in = S_EMIT_PT;
            end else begin
               level_in = level_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_EMIT_PT: begin
            if (!status.out_busy) begin
               if (k_ff == KW'(CURVE_STEPS - 1)) begin
                  state_in = S_EMIT_END;
               end else begin
                  k_in     = k_ff + KW'(1);
                  level_in = 2'd1;
                  state_in = S_MUL;
               end
            end
         end
         S_EMIT_END: begin
            if (!status.out_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         level_ff <= 2'd1;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         k_ff     <= k_in;
      end
   end

endmodule

@@ rtl/core/pcf_datapath.sv @@
// Datapath of the path curve flattener: operand capture, pen state,
// six lerp lanes (three per axis), curve parameter and output register.
// Depends on pcf_pkg.
module pcf_datapath #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  pcf_pkg::cmd_type    cmd,
   output pcf_pkg::status_type status,
   input  logic [3:0]          req_op,
   input  logic                req_absolute,
   input  logic signed [31:0]  req_ctrl1_x,
   input  logic signed [31:0]  req_ctrl1_y,
   input  logic signed [31:0]  req_ctrl2_x,
   input  logic signed [31:0]  req_ctrl2_y,
   input  logic signed [31:0]  req_end_x,
   input  logic signed [31:0]  req_end_y,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_motion,
   output logic signed [31:0]  rsp_point_x,
   output logic signed [31:0]  rsp_point_y,
   output logic                rsp_x_present,
   output logic                rsp_y_present,
   output logic [31:0]         rsp_feed,
   output logic                rsp_last
);

   localparam int CW = COORD_WIDTH;
   localparam int SW = ((CW > 32) ? CW : 32) + 4;
   localparam int DW = CW + 1;
   localparam int PW = DW + pcf_pkg::T_WIDTH + 1;
   localparam logic signed [SW-1:0] CMAX = SW'((65'sd1 <<< (CW - 1)) - 65'sd1);
   localparam logic signed [SW-1:0] CMIN = ~CMAX;
   localparam logic signed [SW-1:0] OMAX = SW'(65'sd2147483647);
   localparam logic signed [SW-1:0] OMIN = ~OMAX;

   typedef logic signed [CW-1:0] coord_type;

   function automatic coord_type sat_cw(input logic signed [SW-1:0] v);
      coord_type r;
      if (v > CMAX)      r = CMAX[CW-1:0];
      else if (v < CMIN) r = CMIN[CW-1:0];
      else               r = v[CW-1:0];
      return r;
   endfunction

   function automatic logic [31:0] sat_out(input coord_type v);
      logic signed [SW-1:0] w;
      logic [31:0]          r;
      w = SW'(v);
      if (w > OMAX)      r = OMAX[31:0];
      else if (w < OMIN) r = OMIN[31:0];
      else               r = w[31:0];
      return r;
   endfunction

   // Captured command.
   logic [3:0]  op_ff;
   logic        abs_ff;
   coord_type   c1_ff [2];
   coord_type   c2_ff [2];
   coord_type   e_ff  [2];

   // Path state, index 0 is x and 1 is y.
   coord_type   pen_ff [2], pen_in [2];
   coord_type   sub_ff [2], sub_in [2];
   coord_type   cref_ff [2], cref_in [2];
   coord_type   qref_ff [2], qref_in [2];

   // Control polygon, lerp results and lane pipeline.
   coord_type              p_ff [2][4], p_in [2][4];
   coord_type              w_ff [2][3];
   coord_type              la_ff [2][3];
   logic signed [PW-1:0]   prod_ff [2][3];

   // Curve parameter.
   logic [pcf_pkg::TQ_WIDTH-1:0] tq_ff;
   logic [pcf_pkg::TR_WIDTH-1:0] tr_ff;
   logic [pcf_pkg::T_WIDTH-1:0]  t_cur;
   logic [pcf_pkg::TQ_WIDTH-1:0] tq_next;
   logic [pcf_pkg::TR_WIDTH:0]   tr_sum;

   // Feed register and output register.
   logic [31:0] feed_ff;
   logic        rsp_valid_ff;
   logic        motion_ff, xp_ff, yp_ff, last_ff;
   logic [31:0] px_out_ff, py_out_ff, feed_out_ff;

   logic [3:0]  op_sel;

   assign op_sel = op_ff;

   // Command class for the controller.
   always_comb begin
      unique case (op_sel)
         pcf_pkg::OP_MOVE, pcf_pkg::OP_LINE, pcf_pkg::OP_HLINE,
         pcf_pkg::OP_VLINE, pcf_pkg::OP_CLOSE:
            status.kind = pcf_pkg::KIND_SINGLE;
         pcf_pkg::OP_CUBIC, pcf_pkg::OP_SCUBIC, pcf_pkg::OP_QUAD,
         pcf_pkg::OP_SQUAD:
            status.kind = pcf_pkg::KIND_CURVE;
         default:
            status.kind = pcf_pkg::KIND_NONE;
      endcase
   end
   assign status.cubic    = (op_sel == pcf_pkg::OP_CUBIC) || (op_sel == pcf_pkg::OP_SCUBIC);
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   // Capture the transaction, saturating each coordinate field to the coordinate width.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         abs_ff   <= req_absolute;
         c1_ff[0] <= sat_cw(SW'(req_ctrl1_x));
         c1_ff[1] <= sat_cw(SW'(req_ctrl1_y));
         c2_ff[0] <= sat_cw(SW'(req_ctrl2_x));
         c2_ff[1] <= sat_cw(SW'(req_ctrl2_y));
         e_ff[0]  <= sat_cw(SW'(req_end_x));
         e_ff[1]  <= sat_cw(SW'(req_end_y));
      end
   end

   // Resolve relative operands and reflections, and work out the new state.
   always_comb begin
      coord_type e_r  [2];
      coord_type c1_r [2];
      coord_type c2_r [2];
      coord_type rc   [2];
      coord_type rq   [2];
      for (int a = 0; a < 2; a++) begin
         e_r[a]  = abs_ff ? e_ff[a]  : sat_cw(SW'(pen_ff[a]) + SW'(e_ff[a]));
         c1_r[a] = abs_ff ? c1_ff[a] : sat_cw(SW'(pen_ff[a]) + SW'(c1_ff[a]));
         c2_r[a] = abs_ff ? c2_ff[a] : sat_cw(SW'(pen_ff[a]) + SW'(c2_ff[a]));
         rc[a]   = sat_cw((SW'(pen_ff[a]) <<< 1) - SW'(cref_ff[a]));
         rq[a]   = sat_cw((SW'(pen_ff[a]) <<< 1) - SW'(qref_ff[a]));
      end
      for (int a = 0; a < 2; a++) begin
         pen_in[a]  = pen_ff[a];
         sub_in[a]  = sub_ff[a];
         cref_in[a] = cref_ff[a];
         qref_in[a] = qref_ff[a];
         for (int i = 0; i < 4; i++) p_in[a][i] = p_ff[a][i];
      end
      unique case (op_sel)
         pcf_pkg::OP_MOVE: begin
            for (int a = 0; a < 2; a++) begin
               pen_in[a] = e_r[a];
               sub_in[a] = e_r[a];
            end
         end
         pcf_pkg::OP_LINE, pcf_pkg::OP_HLINE, pcf_pkg::OP_VLINE: begin
            pen_in[0] = (op_sel != pcf_pkg::OP_VLINE) ? e_r[0] : pen_ff[0];
            pen_in[1] = (op_sel != pcf_pkg::OP_HLINE) ? e_r[1] : pen_ff[1];
            for (int a = 0; a < 2; a++) begin
               cref_in[a] = pen_in[a];
               qref_in[a] = pen_in[a];
            end
         end
         pcf_pkg::OP_CUBIC, pcf_pkg::OP_SCUBIC: begin
            for (int a = 0; a < 2; a++) begin
               p_in[a][0] = pen_ff[a];
               p_in[a][1] = (op_sel == pcf_pkg::OP_SCUBIC) ? rc[a] : c1_r[a];
               p_in[a][2] = c2_r[a];
               p_in[a][3] = e_r[a];
               pen_in[a]  = e_r[a];
               qref_in[a] = e_r[a];
               cref_in[a] = c2_r[a];
            end
         end
         pcf_pkg::OP_QUAD, pcf_pkg::OP_SQUAD: begin
            for (int a = 0; a < 2; a++) begin
               p_in[a][0] = pen_ff[a];
               p_in[a][1] = (op_sel == pcf_pkg::OP_SQUAD) ? rq[a] : c1_r[a];
               p_in[a][2] = e_r[a];
               p_in[a][3] = e_r[a];
               pen_in[a]  = e_r[a];
               cref_in[a] = e_r[a];
               qref_in[a] = p_in[a][1];
            end
         end
         pcf_pkg::OP_CLOSE: begin
            for (int a = 0; a < 2; a++) pen_in[a] = sub_ff[a];
         end
         pcf_pkg::OP_END: begin
            for (int a = 0; a < 2; a++) begin
               pen_in[a]  = '0;
               sub_in[a]  = '0;
               cref_in[a] = '0;
               qref_in[a] = '0;
            end
         end
         default: ;
      endcase
   end

   // Path state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 2; a++) begin
            pen_ff[a]  <= '0;
            sub_ff[a]  <= '0;
            cref_ff[a] <= '0;
            qref_ff[a] <= '0;
         end
      end else if (cmd.resolve) begin
         pen_ff  <= pen_in;
         sub_ff  <= sub_in;
         cref_ff <= cref_in;
         qref_ff <= qref_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resolve) p_ff <= p_in;
   end

   // Curve parameter: t = min(1.0, k * 0.03 rounded to 1/65536), stepped after each point.
   assign t_cur   = (tq_ff > pcf_pkg::TQ_WIDTH'(pcf_pkg::T_ONE))
                  ? pcf_pkg::T_WIDTH'(pcf_pkg::T_ONE) : tq_ff[pcf_pkg::T_WIDTH-1:0];
   assign tr_sum  = {1'b0, tr_ff} + (pcf_pkg::TR_WIDTH + 1)'(pcf_pkg::T_R_STEP);
   assign tq_next = tq_ff + pcf_pkg::TQ_WIDTH'(pcf_pkg::T_Q_STEP);

   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         tq_ff <= '0;
         tr_ff <= pcf_pkg::TR_WIDTH'(pcf_pkg::T_R_START);
      end else if (cmd.emit_pt) begin
         if (tr_sum >= (pcf_pkg::TR_WIDTH + 1)'(pcf_pkg::T_DIVISOR)) begin
            tq_ff <= tq_next + pcf_pkg::TQ_WIDTH'(1);
            tr_ff <= pcf_pkg::TR_WIDTH'(tr_sum - (pcf_pkg::TR_WIDTH + 1)'(pcf_pkg::T_DIVISOR));
         end else begin
            tq_ff <= tq_next;
            tr_ff <= tr_sum[pcf_pkg::TR_WIDTH-1:0];
         end
      end
   end

   // Lerp lanes: the multiply stage registers (b - a) * t, the accumulate
   // stage adds the rounded product to a and saturates.
   always_ff @(posedge clock) begin
      coord_type             op_a;
      coord_type             op_b;
      logic signed [DW-1:0]  d;
      logic signed [PW-1:0]  part;
      for (int a = 0; a < 2; a++) begin
         for (int i = 0; i < 3; i++) begin
            op_a = cmd.first_level ? p_ff[a][i]   : w_ff[a][i];
            op_b = cmd.first_level ? p_ff[a][i+1] : w_ff[a][(i == 2) ? 2 : i + 1];
            d    = DW'(op_b) - DW'(op_a);
            part = (prod_ff[a][i] + PW'(pcf_pkg::ROUND_HALF)) >>> 16;
            if (cmd.mul) begin
               la_ff[a][i]   <= op_a;
               prod_ff[a][i] <= PW'(d) * PW'($signed({1'b0, t_cur}));
            end
            if (cmd.acc) begin
               w_ff[a][i] <= sat_cw(SW'(la_ff[a][i]) + part[SW-1:0]);
            end
         end
      end
   end

   // Feed rate register.
   always_ff @(posedge clock) begin
      if (reset)          feed_ff <= '0;
      else if (csr_wr_en) feed_ff <= csr_wr_data;
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset)                            rsp_valid_ff <= 1'b0;
      else if (cmd.emit_pt || cmd.emit_end) rsp_valid_ff <= 1'b1;
      else if (rsp_ready)                   rsp_valid_ff <= 1'b0;
   end

   // Output register payload: a curve point or the pen after the command.
   always_ff @(posedge clock) begin
      logic mv, xp, yp;
      mv = (op_sel != pcf_pkg::OP_MOVE);
      xp = (op_sel != pcf_pkg::OP_VLINE);
      yp = (op_sel != pcf_pkg::OP_HLINE);
      if (cmd.emit_pt) begin
         motion_ff   <= 1'b1;
         px_out_ff   <= sat_out(w_ff[0][0]);
         py_out_ff   <= sat_out(w_ff[1][0]);
         xp_ff       <= 1'b1;
         yp_ff       <= 1'b1;
         feed_out_ff <= feed_ff;
         last_ff     <= 1'b0;
      end else if (cmd.emit_end) begin
         motion_ff   <= mv;
         px_out_ff   <= xp ? sat_out(pen_ff[0]) : '0;
         py_out_ff   <= yp ? sat_out(pen_ff[1]) : '0;
         xp_ff       <= xp;
         yp_ff       <= yp;
         feed_out_ff <= mv ? feed_ff : '0;
         last_ff     <= 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_motion    = motion_ff;
   assign rsp_point_x   = px_out_ff;
   assign rsp_point_y   = py_out_ff;
   assign rsp_x_present = xp_ff;
   assign rsp_y_present = yp_ff;
   assign rsp_feed      = feed_out_ff;
   assign rsp_last      = last_ff;

endmodule

@@ rtl/core/path_curve_flattener_unit.sv @@
// Top level of the path curve flattener.
// Depends on pcf_pkg, pcf_ctrl and pcf_datapath.
//
// Use: each req transaction carries one path command (move, line, horizontal
// or vertical line, cubic, smooth cubic, quadratic, smooth quadratic, close,
// end), absolute or relative to the pen. Each rsp transaction carries one
// point; last marks the final point of a command. End and unknown codes
// give no point. csr_wr_en writes the feed rate, which is copied onto every
// feed move; write it only while the block is idle.
// Timing: one command is taken, then req_ready stays low until its last
// point has been loaded into the output register. Curves evaluate each
// point through the shared lerp lanes, a multiply state and an accumulate
// state per de Casteljau level (3 levels cubic, 2 quadratic), then load
// the point into the output register.
// Reset: synchronous; clears the pen, subpath start, control references,
// feed rate and the valid flag of the output register.
// Stall: a held rsp freezes the controller until the point is taken; the
// next command is still accepted while the last point waits.
module path_curve_flattener_unit #(
   parameter int CURVE_STEPS = 34,
   parameter int COORD_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_op,
   input  logic               req_absolute,
   input  logic signed [31:0] req_ctrl1_x,
   input  logic signed [31:0] req_ctrl1_y,
   input  logic signed [31:0] req_ctrl2_x,
   input  logic signed [31:0] req_ctrl2_y,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_motion,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic               rsp_x_present,
   output logic               rsp_y_present,
   output logic [31:0]        rsp_feed,
   output logic               rsp_last
);

   pcf_pkg::cmd_type    cmd;
   pcf_pkg::status_type status;

   pcf_ctrl #(
      .CURVE_STEPS(CURVE_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcf_datapath #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_op        (req_op),
      .req_absolute  (req_absolute),
      .req_ctrl1_x   (req_ctrl1_x),
      .req_ctrl1_y   (req_ctrl1_y),
      .req_ctrl2_x   (req_ctrl2_x),
      .req_ctrl2_y   (req_ctrl2_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_motion    (rsp_motion),
      .rsp_point_x   (rsp_point_x),
      .rsp_point_y   (rsp_point_y),
      .rsp_x_present (rsp_x_present),
      .rsp_y_present (rsp_y_present),
      .rsp_feed      (rsp_feed),
      .rsp_last      (rsp_last)
   );

endmodule

@@ rtl/core/pcf_checker.sv @@
// Port-level checker for the path curve flattener, bound to the top level.
// Depends on path_curve_flattener_unit only through its ports.
module pcf_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_motion,
   input logic signed [31:0] rsp_point_x,
   input logic               rsp_x_present,
   input logic [31:0]        rsp_feed
);

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled result stays offered.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // Rapid moves carry no feed rate.
   a_rapid_feed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_motion |-> rsp_feed == 32'd0)
      else $error("feed on rapid move");

   // An absent x axis reads as zero.
   a_absent_x: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_x_present |-> rsp_point_x == 32'sd0)
      else $error("absent x not zero");

endmodule

bind path_curve_flattener_unit pcf_checker u_pcf_checker (.*);
